[hdl/two_tone_arm_length_model_top_macros.svh]
// Assertion macros for the two-tone arm-length model.
`ifndef TWO_TONE_ARM_LENGTH_MODEL_TOP_MACROS_SVH
`define TWO_TONE_ARM_LENGTH_MODEL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TTAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttal assertion failed");

// Next-cycle implication, checked through reset as well.
`define TTAL_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ttal assertion failed");

`endif

[hdl/ttal_pkg.sv]
// Package with types, constants and helper functions of the two-tone arm-length model.
package ttal_pkg;

   localparam int SINE_BITS = 24;
   localparam int SINE_SH = 32 - SINE_BITS;
   localparam int SMAG_W = SINE_BITS + 1;
   localparam int SINE_W = SINE_BITS + 2;
   localparam int RND_SH = SINE_BITS + 5;

   localparam int A_W = 46;
   localparam int AMAG_W = 45;
   localparam int ALO_W = 23;
   localparam int EMAG_W = 40;
   localparam int ELO_W = 20;
   localparam int P1_W = AMAG_W + SMAG_W;
   localparam int P2_W = EMAG_W + SMAG_W;
   localparam int T1_W = P1_W - RND_SH + 2;
   localparam int T2_W = P2_W - RND_SH + 2;
   localparam int DEV_W = T1_W + 2;
   localparam int FULL_W = DEV_W + 1;

   localparam int PHASE_LAT = 5;
   localparam int SINE_LAT = 18;
   localparam int SCALE_LAT = 9;
   localparam int TOTAL_LAT = PHASE_LAT + SINE_LAT + SCALE_LAT;

   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [31:0] THIRD_TURN = 32'd1431655765;
   localparam logic [31:0] TWO_THIRD_TURN = 32'd2863311531;

   localparam logic [3:0] CSR_NOMINAL_LENGTH = 4'd0;
   localparam logic [3:0] CSR_LENGTH_OFFSET = 4'd1;
   localparam logic [3:0] CSR_TIME_OFFSET = 4'd2;
   localparam logic [3:0] CSR_ROTATION_AMP = 4'd3;
   localparam logic [3:0] CSR_ECCENTRIC_AMP = 4'd4;
   localparam logic [3:0] CSR_INITIAL_PHASE = 4'd5;
   localparam logic [3:0] CSR_ORIENTATION = 4'd6;
   localparam logic [3:0] CSR_ORBIT_RATE = 4'd7;

   localparam logic [38:0] NOMINAL_LENGTH_RST = 39'd71632323556;
   localparam logic [31:0] ORBIT_RATE_RST = 32'd8919600;

   typedef struct packed {
      logic [1:0] arm_number;
      logic downlink;
      logic signed [47:0] sample_time;
   } req_type;

   typedef struct packed {
      logic signed [39:0] full_length;
      logic signed [39:0] length_deviation;
   } rsp_type;

   typedef struct packed {
      logic [38:0] nominal_length;
      logic signed [39:0] length_offset;
      logic signed [47:0] time_offset;
      logic signed [39:0] rotation_amp;
      logic signed [39:0] eccentric_amp;
      logic [31:0] initial_phase;
      logic orientation;
      logic [31:0] orbit_rate;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ph1;
      logic [31:0] ph3;
      logic down;
   } phase_type;

   // Reciprocal of a series divisor, exact for dividends below 2^32.
   function automatic logic [32:0] recip_mag(input logic [1:0] step, input logic cos_sel);
      logic [32:0] m;
      case ({cos_sel, step})
         3'b000: m = 33'd7635497416;
         3'b001: m = 33'd6544712071;
         3'b010: m = 33'd6871947674;
         3'b011: m = 33'd5726623062;
         3'b100: m = 33'd6108397933;
         3'b101: m = 33'd4908534053;
         3'b110: m = 33'd4581298450;
         3'b111: m = 33'd5726623062;
         default: m = 33'd0;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] recip_shift(input logic [1:0] step, input logic cos_sel);
      logic [5:0] s;
      case ({cos_sel, step})
         3'b000: s = 6'd39;
         3'b001: s = 6'd38;
         3'b010: s = 6'd37;
         3'b011: s = 6'd35;
         3'b100: s = 6'd39;
         3'b101: s = 6'd38;
         3'b110: s = 6'd37;
         3'b111: s = 6'd36;
         default: s = 6'd39;
      endcase
      return s;
   endfunction

   function automatic logic signed [39:0] sat_s40(input logic signed [FULL_W-1:0] v);
      logic [FULL_W-40:0] upper;
      logic signed [39:0] r;
      upper = v[FULL_W-1:39];
      if ((&upper) || !(|upper)) begin
         r = v[39:0];
      end else if (v[FULL_W-1]) begin
         r = {1'b1, 39'd0};
      end else begin
         r = {1'b0, {39{1'b1}}};
      end
      return r;
   endfunction

endpackage

[hdl/two_tone_arm_length_model_top.sv]
// Top level of the two-tone arm-length model with configuration registers.
//
//   port group   direction   handshake
//   req_         in          start / busy, taken when start is high and busy low
//   rsp_         out         rsp_strobe, one cycle per word, no backpressure
//   csr_         in          csr_valid / csr_ready, index and data
//
// A new word can be taken every cycle while busy is low; each result passes
// through the phase, sine and scaling pipeline stages in the order taken.
// Synchronous reset clears all valid bits and loads the register defaults;
// busy and csr_ready are held off for the cycle after reset.
// csr_ready is also low while start is high or any word is in flight.
// The receiver cannot stall, so the pipeline never holds.
module two_tone_arm_length_model_top import ttal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_word,
   output logic        rsp_strobe,
   output rsp_type     rsp_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_data
);

`include "two_tone_arm_length_model_top_macros.svh"

   logic busy_ff;
   cfg_type cfg_ff, cfg_in;
   logic accept, csr_write;
   logic [5:0] inflight_ff, inflight_in;

   logic ph_vld;
   phase_type phase;
   logic s1_vld, s3_vld;
   logic signed [SINE_W-1:0] sin1, sin3;
   logic [SINE_LAT-1:0] down_ff;

   assign busy = busy_ff;
   assign csr_ready = !busy_ff && !start && (inflight_ff == 6'd0);
   assign accept = start && !busy_ff;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_comb begin
      inflight_in = inflight_ff + 6'(accept) - 6'(rsp_strobe);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_NOMINAL_LENGTH: cfg_in.nominal_length = csr_data[38:0];
            CSR_LENGTH_OFFSET: cfg_in.length_offset = csr_data[39:0];
            CSR_TIME_OFFSET: cfg_in.time_offset = csr_data;
            CSR_ROTATION_AMP: cfg_in.rotation_amp = csr_data[39:0];
            CSR_ECCENTRIC_AMP: cfg_in.eccentric_amp = csr_data[39:0];
            CSR_INITIAL_PHASE: cfg_in.initial_phase = csr_data[31:0];
            CSR_ORIENTATION: cfg_in.orientation = csr_data[0];
            CSR_ORBIT_RATE: cfg_in.orbit_rate = csr_data[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_length <= NOMINAL_LENGTH_RST;
         cfg_ff.length_offset <= '0;
         cfg_ff.time_offset <= '0;
         cfg_ff.rotation_amp <= '0;
         cfg_ff.eccentric_amp <= '0;
         cfg_ff.initial_phase <= '0;
         cfg_ff.orientation <= 1'b1;
         cfg_ff.orbit_rate <= ORBIT_RATE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttal_phase u_phase (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (accept),
      .req     (req_word),
      .cfg     (cfg_ff),
      .out_vld (ph_vld),
      .phase   (phase)
   );

   ttal_sine u_sine1 (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (ph_vld),
      .phase   (phase.ph1),
      .out_vld (s1_vld),
      .sine    (sin1)
   );

   ttal_sine u_sine3 (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (ph_vld),
      .phase   (phase.ph3),
      .out_vld (s3_vld),
      .sine    (sin3)
   );

   always_ff @(posedge clock) begin
      down_ff <= {down_ff[SINE_LAT-2:0], phase.down};
   end

   ttal_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s1_vld && s3_vld),
      .down    (down_ff[SINE_LAT-1]),
      .sin1    (sin1),
      .sin3    (sin3),
      .cfg     (cfg_ff),
      .out_vld (rsp_strobe),
      .rsp     (rsp_word)
   );

   `TTAL_ASSERT_IMP(a_latency_fwd, clock, reset, accept, ##TOTAL_LAT rsp_strobe)
   `TTAL_ASSERT_IMP(a_latency_back, clock, reset, rsp_strobe, $past(accept, TOTAL_LAT))
   `TTAL_ASSERT_NEXT(a_busy_after_reset, clock, reset, busy && !csr_ready)

endmodule

[hdl/ttal_phase.sv]
// Orbit phase pipeline: time offset, phase product and arm phase subtraction.
module ttal_phase import ttal_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_vld,
   input  req_type   req,
   input  cfg_type   cfg,
   output logic      out_vld,
   output phase_type phase
);

   localparam logic [1:0] ARM_TWO = 2'd2;
   localparam logic [1:0] ARM_THREE = 2'd3;

   logic [PHASE_LAT-1:0] vld_ff, vld_in;

   logic signed [48:0] t_ff, t_in;
   logic [31:0] armph_ff [3];
   logic [31:0] off3_ff [4];
   logic [PHASE_LAT-1:0] down_ff;
   logic [31:0] armph_in, off3_in, arm_off;
   logic [63:0] plo_ff, plo_in;
   logic [31:0] phi_ff, phi_in, thi;
   logic [63:0] prod_ff, prod_in, prod3;
   logic [31:0] ph1_ff, ph1_in, p3_ff, p3_in;
   logic [31:0] ph1d_ff, ph3_ff, ph3_in;

   always_comb begin
      vld_in = {vld_ff[PHASE_LAT-2:0], in_vld};
      t_in = 49'(req.sample_time) + 49'(cfg.time_offset);
      case (req.arm_number)
         ARM_TWO: arm_off = cfg.orientation ? TWO_THIRD_TURN : THIRD_TURN;
         ARM_THREE: arm_off = cfg.orientation ? THIRD_TURN : TWO_THIRD_TURN;
         default: arm_off = 32'd0;
      endcase
      armph_in = cfg.initial_phase + arm_off;
      off3_in = cfg.initial_phase + {cfg.initial_phase[30:0], 1'b0};
      thi = {{15{t_ff[48]}}, t_ff[48:32]};
      plo_in = 64'(cfg.orbit_rate) * 64'(t_ff[31:0]);
      phi_in = cfg.orbit_rate * thi;
      prod_in = {plo_ff[63:32] + phi_ff, plo_ff[31:0]};
      ph1_in = prod_ff[63:32] - armph_ff[2];
      prod3 = prod_ff + {prod_ff[62:0], 1'b0};
      p3_in = prod3[63:32];
      ph3_in = p3_ff - off3_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      armph_ff[0] <= armph_in;
      off3_ff[0] <= off3_in;
      down_ff <= {down_ff[PHASE_LAT-2:0], req.downlink};
      for (int k = 1; k < 3; k++) begin
         armph_ff[k] <= armph_ff[k-1];
      end
      for (int k = 1; k < 4; k++) begin
         off3_ff[k] <= off3_ff[k-1];
      end
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      prod_ff <= prod_in;
      ph1_ff <= ph1_in;
      p3_ff <= p3_in;
      ph1d_ff <= ph1_ff;
      ph3_ff <= ph3_in;
   end

   assign out_vld = vld_ff[PHASE_LAT-1];
   assign phase.ph1 = ph1d_ff;
   assign phase.ph3 = ph3_ff;
   assign phase.down = down_ff[PHASE_LAT-1];

endmodule

[hdl/ttal_sine.sv]
// Pipelined fixed-point sine of a turn phase using octant folding and Horner series.
module ttal_sine import ttal_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic [31:0]              phase,
   output logic                     out_vld,
   output logic signed [SINE_W-1:0] sine
);

   typedef struct packed {
      logic cos_sel;
      logic neg;
      logic [31:0] s;
      logic [31:0] th;
   } side_type;

   localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
   localparam logic [33:0] SINE_HALF = 34'(34'd1 << SINE_SH) >> 1;

   logic [SINE_LAT-1:0] vld_ff, vld_in;

   logic [29:0] r_lo;
   logic odd, cos_in, flip;
   logic [30:0] v_full;
   logic [29:0] v_ff, v_in;
   logic cos0_ff, neg0_ff, cos1_ff, neg1_ff;
   logic [31:0] th_ff, th_in;
   logic [61:0] th_prod;
   logic [63:0] s_prod;
   side_type head_ff, head_in;

   side_type side_src [4];
   logic [32:0] t_src [4];
   side_type side_a_ff [4];
   side_type side_b_ff [4];
   side_type side_c_ff [4];
   logic [31:0] mq_ff [4];
   logic [31:0] mq_in [4];
   logic [64:0] dq_ff [4];
   logic [64:0] dq_in [4];
   logic [32:0] t_ff [4];
   logic [32:0] t_in [4];

   logic [31:0] x_sel, p_ff, p_in;
   logic [64:0] p_prod;
   logic cosf_ff, negf_ff, negm_ff;
   logic [32:0] mag_ff, mag_in;
   logic [33:0] rnd;
   logic [SMAG_W-1:0] m_mag;
   logic signed [SINE_W-1:0] sine_ff, sine_in;

   always_comb begin
      vld_in = {vld_ff[SINE_LAT-2:0], in_vld};
      r_lo = phase[29:0];
      odd = phase[30];
      cos_in = odd ? (r_lo < 30'h2000_0000) : (r_lo > 30'h2000_0000);
      flip = odd ^ cos_in;
      v_full = 31'h4000_0000 - {1'b0, r_lo};
      v_in = flip ? v_full[29:0] : r_lo;
      th_prod = 62'(v_ff) * 62'(TWO_PI_Q29);
      th_in = th_prod[60:29];
      s_prod = 64'(th_ff) * 64'(th_ff);
      head_in.cos_sel = cos1_ff;
      head_in.neg = neg1_ff;
      head_in.s = s_prod[63:32];
      head_in.th = th_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      cos0_ff <= cos_in;
      neg0_ff <= phase[31];
      th_ff <= th_in;
      cos1_ff <= cos0_ff;
      neg1_ff <= neg0_ff;
      head_ff <= head_in;
   end

   for (genvar k = 0; k < 4; k++) begin : g_step
      logic [64:0] mq_prod;
      logic [64:0] dq_shift;

      if (k == 0) begin : g_first
         assign side_src[k] = head_ff;
         assign t_src[k] = Q32_ONE;
      end else begin : g_next
         assign side_src[k] = side_c_ff[k-1];
         assign t_src[k] = t_ff[k-1];
      end

      always_comb begin
         mq_prod = 65'(side_src[k].s) * 65'(t_src[k]);
         mq_in[k] = mq_prod[63:32];
         dq_in[k] = 65'(mq_ff[k]) * 65'(recip_mag(2'(k), side_a_ff[k].cos_sel));
         dq_shift = dq_ff[k] >> recip_shift(2'(k), side_b_ff[k].cos_sel);
         t_in[k] = Q32_ONE - dq_shift[32:0];
      end

      always_ff @(posedge clock) begin
         side_a_ff[k] <= side_src[k];
         mq_ff[k] <= mq_in[k];
         side_b_ff[k] <= side_a_ff[k];
         dq_ff[k] <= dq_in[k];
         side_c_ff[k] <= side_b_ff[k];
         t_ff[k] <= t_in[k];
      end
   end

   always_comb begin
      x_sel = side_c_ff[3].cos_sel ? side_c_ff[3].s : side_c_ff[3].th;
      p_prod = 65'(x_sel) * 65'(t_ff[3]);
      p_in = p_prod[63:32];
      mag_in = cosf_ff ? (Q32_ONE - {2'b00, p_ff[31:1]}) : {1'b0, p_ff};
      rnd = {1'b0, mag_ff} + SINE_HALF;
      m_mag = SMAG_W'(rnd >> SINE_SH);
      sine_in = negm_ff ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      cosf_ff <= side_c_ff[3].cos_sel;
      negf_ff <= side_c_ff[3].neg;
      mag_ff <= mag_in;
      negm_ff <= negf_ff;
      sine_ff <= sine_in;
   end

   assign out_vld = vld_ff[SINE_LAT-1];
   assign sine = sine_ff;

endmodule

[hdl/ttal_scale.sv]
// Amplitude products with rounding, deviation sum and saturation.
module ttal_scale import ttal_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic                     down,
   input  logic signed [SINE_W-1:0] sin1,
   input  logic signed [SINE_W-1:0] sin3,
   input  cfg_type                  cfg,
   output logic                     out_vld,
   output rsp_type                  rsp
);

   localparam int AHI_W = AMAG_W - ALO_W;
   localparam int EHI_W = EMAG_W - ELO_W;
   localparam logic [P1_W:0] HALF1 = (P1_W + 1)'(1) << (RND_SH - 1);
   localparam logic [P2_W:0] HALF2 = (P2_W + 1)'(1) << (RND_SH - 1);

   logic [SCALE_LAT-1:0] vld_ff, vld_in;

   logic signed [A_W-1:0] cm32, em_ext, em15, a_in, a_ff;
   logic signed [SINE_W-1:0] s1_ff, s3_ff;

   logic [A_W-1:0] a_abs;
   logic [SINE_W-1:0] s1_abs, s3_abs;
   logic [39:0] e_abs;
   logic [AMAG_W-1:0] am_ff;
   logic [EMAG_W-1:0] em_ff;
   logic [SMAG_W-1:0] sm1_ff, sm3_ff;
   logic [3:0] neg1_ff, neg2_ff;

   logic [ALO_W+SMAG_W-1:0] pp1lo_ff;
   logic [AHI_W+SMAG_W-1:0] pp1hi_ff;
   logic [ELO_W+SMAG_W-1:0] pp2lo_ff;
   logic [EHI_W+SMAG_W-1:0] pp2hi_ff;
   logic [P1_W-1:0] prod1_ff;
   logic [P2_W-1:0] prod2_ff;
   logic [P1_W:0] rnd1;
   logic [P2_W:0] rnd2;
   logic [T1_W-2:0] mag1_ff;
   logic [T2_W-2:0] mag2_ff;
   logic signed [T1_W-1:0] t1_ff;
   logic signed [T2_W-1:0] t2_ff;
   logic signed [DEV_W-1:0] dev_ff;
   logic signed [FULL_W-1:0] full_ff;
   logic signed [39:0] dsat_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      vld_in = {vld_ff[SCALE_LAT-2:0], in_vld};
      cm32 = A_W'(cfg.rotation_amp) <<< 5;
      em_ext = A_W'(cfg.eccentric_amp);
      em15 = (em_ext <<< 4) - em_ext;
      a_in = ((cfg.orientation ^ down) ? cm32 : -cm32) - em15;
      a_abs = a_ff[A_W-1] ? A_W'(-a_ff) : a_ff;
      s1_abs = s1_ff[SINE_W-1] ? SINE_W'(-s1_ff) : s1_ff;
      s3_abs = s3_ff[SINE_W-1] ? SINE_W'(-s3_ff) : s3_ff;
      e_abs = cfg.eccentric_amp[39] ? 40'(-cfg.eccentric_amp) : cfg.eccentric_amp;
      rnd1 = {1'b0, prod1_ff} + HALF1;
      rnd2 = {1'b0, prod2_ff} + HALF2;
      rsp_in.full_length = sat_s40(full_ff);
      rsp_in.length_deviation = dsat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      s1_ff <= sin1;
      s3_ff <= sin3;

      am_ff <= a_abs[AMAG_W-1:0];
      em_ff <= e_abs;
      sm1_ff <= s1_abs[SMAG_W-1:0];
      sm3_ff <= s3_abs[SMAG_W-1:0];
      neg1_ff <= {neg1_ff[2:0], a_ff[A_W-1] ^ s1_ff[SINE_W-1]};
      neg2_ff <= {neg2_ff[2:0], cfg.eccentric_amp[39] ^ s3_ff[SINE_W-1]};

      pp1lo_ff <= (ALO_W + SMAG_W)'(am_ff[ALO_W-1:0]) * (ALO_W + SMAG_W)'(sm1_ff);
      pp1hi_ff <= (AHI_W + SMAG_W)'(am_ff[AMAG_W-1:ALO_W]) * (AHI_W + SMAG_W)'(sm1_ff);
      pp2lo_ff <= (ELO_W + SMAG_W)'(em_ff[ELO_W-1:0]) * (ELO_W + SMAG_W)'(sm3_ff);
      pp2hi_ff <= (EHI_W + SMAG_W)'(em_ff[EMAG_W-1:ELO_W]) * (EHI_W + SMAG_W)'(sm3_ff);

      prod1_ff <= (P1_W'(pp1hi_ff) << ALO_W) + P1_W'(pp1lo_ff);
      prod2_ff <= (P2_W'(pp2hi_ff) << ELO_W) + P2_W'(pp2lo_ff);

      mag1_ff <= (T1_W - 1)'(rnd1 >> RND_SH);
      mag2_ff <= (T2_W - 1)'(rnd2 >> RND_SH);

      t1_ff <= neg1_ff[3] ? -$signed({1'b0, mag1_ff}) : $signed({1'b0, mag1_ff});
      t2_ff <= neg2_ff[3] ? -$signed({1'b0, mag2_ff}) : $signed({1'b0, mag2_ff});

      dev_ff <= DEV_W'(cfg.length_offset) + DEV_W'(t1_ff) + DEV_W'(t2_ff);

      full_ff <= $signed(FULL_W'(cfg.nominal_length)) + FULL_W'(dev_ff);
      dsat_ff <= sat_s40(FULL_W'(dev_ff));

      rsp_ff <= rsp_in;
   end

   assign out_vld = vld_ff[SCALE_LAT-1];
   assign rsp = rsp_ff;

endmodule
